// ===== src/dqvr_pkg.sv =====
// dqvr_pkg: shared types and constants of the deque with value removal
// operation and status codes, command and response item structs
// no dependencies
`timescale 1ns / 1ps

package dqvr_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 5;

    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_LIST_FWD   = 3'd2,
        KIND_LIST_BWD   = 3'd3,
        KIND_REMOVE     = 3'd4,
        KIND_CLEAR      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [DATA_W-1:0]  item_value;
    } cmd_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  entry_value;
        logic [COUNT_W-1:0]        removed_count;
        logic                      last;
    } rsp_t;

endpackage

// ===== src/dqvr_ram.sv =====
// dqvr_ram: generic single-port-write, single-port-read ram
// registered read data, no reset on contents
// no dependencies
`timescale 1ns / 1ps

module dqvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/deque_with_value_removal.sv =====
// deque_with_value_removal: circular deque of signed values with removal by value
// depends on dqvr_pkg and dqvr_ram
//
//  channel | dir | handshake          | payload
//  cmd     | in  | cmd_valid/cmd_stall | cmd_t: kind, item_value
//  rsp     | out | rsp_valid/rsp_stall | rsp_t: status, entry_value, removed_count, last
//
// push, clear and empty-store results load directly when the response register is free
// a list or remove holds cmd_stall from acceptance until its last result is loaded, one
// ram read per cycle behind the registered read data while no list entry is held back;
// a remove writes back each kept entry; list entries and results wait on rsp_stall
// after reset the deque is empty; store contents are undefined until written, no clear pass
// cmd_stall is high while a list or remove is in progress or a result waits to be loaded
`timescale 1ns / 1ps

module deque_with_value_removal
    import dqvr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] CAP_LAST = IDX_W'(CAPACITY - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LIST   = 4'b0010,
        S_REMOVE = 4'b0100,
        S_FIN    = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    kind_t               op_reg, op_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]    em_cnt_reg, em_cnt_next;
    logic [CNT_W-1:0]    kept_reg, kept_next;
    logic                rv_reg, rv_next;
    rsp_t                res_reg, res_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [DATA_W-1:0]   rd_data;

    logic                out_free;
    logic                cmd_acc;
    logic                have_res;
    rsp_t                res;
    logic                move;
    logic                issue;
    logic                match;
    logic [CNT_W-1:0]    logical;
    logic [CNT_W-1:0]    kept_fin;
    logic [CNT_W-1:0]    removed;
    logic [COUNT_W+CNT_W-1:0] removed_ext;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] ofs);
        logic [IDX_W:0] sum;
        begin
            sum = {1'b0, base} + {1'b0, ofs};
            if (sum >= CAP_SUM)
            begin
                sum = sum - CAP_SUM;
            end
            slot_of = sum[IDX_W-1:0];
        end
    endfunction

    dqvr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        occ_next       = occ_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        rd_cnt_next    = rd_cnt_reg;
        em_cnt_next    = em_cnt_reg;
        kept_next      = kept_reg;
        rv_next        = 1'b0;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = cmd.item_value;
        rd_en          = 1'b0;
        rd_addr        = '0;
        have_res       = 1'b0;
        res            = '{status: ST_OK, entry_value: '0, removed_count: '0, last: 1'b1};
        move           = 1'b0;
        issue          = 1'b0;
        match          = 1'b0;
        logical        = '0;
        kept_fin       = kept_reg;
        removed        = '0;
        removed_ext    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    case (cmd.kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK:
                        begin
                            have_res        = 1'b1;
                            res.entry_value = cmd.item_value;
                            if (occ_reg == CAP_CNT)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                occ_next = occ_reg + 1'b1;
                                if (cmd.kind == KIND_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? CAP_LAST
                                                                   : front_reg - 1'b1;
                                    wr_addr    = front_next;
                                end
                                else
                                begin
                                    wr_addr = slot_of(front_reg, occ_reg[IDX_W-1:0]);
                                end
                            end
                        end
                        KIND_LIST_FWD, KIND_LIST_BWD, KIND_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                have_res   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                op_next     = cmd.kind;
                                val_next    = cmd.item_value;
                                rd_cnt_next = '0;
                                em_cnt_next = '0;
                                kept_next   = '0;
                                state_next  = (cmd.kind == KIND_REMOVE) ? S_REMOVE : S_LIST;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            have_res   = 1'b1;
                            res.status = (occ_reg == '0) ? ST_EMPTY : ST_OK;
                            occ_next   = '0;
                            front_next = '0;
                        end
                        default:
                        begin
                            have_res = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                move    = rv_reg && out_free;
                issue   = (rd_cnt_reg < occ_reg) && (!rv_reg || move);
                logical = (op_reg == KIND_LIST_FWD) ? rd_cnt_reg
                                                    : occ_reg - 1'b1 - rd_cnt_reg;
                rd_en   = issue;
                rd_addr = slot_of(front_reg, logical[IDX_W-1:0]);
                rv_next = issue || (rv_reg && !move);
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (move)
                begin
                    rsp_next.status        = ST_OK;
                    rsp_next.entry_value   = rd_data;
                    rsp_next.removed_count = '0;
                    rsp_next.last          = (em_cnt_reg == occ_reg - 1'b1);
                    rsp_valid_next         = 1'b1;
                    em_cnt_next            = em_cnt_reg + 1'b1;
                    if (em_cnt_reg == occ_reg - 1'b1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REMOVE:
            begin
                issue   = (rd_cnt_reg < occ_reg);
                rd_en   = issue;
                rd_addr = slot_of(front_reg, rd_cnt_reg[IDX_W-1:0]);
                rv_next = issue;
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    match       = (rd_data == val_reg);
                    em_cnt_next = em_cnt_reg + 1'b1;
                    if (!match)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = slot_of(front_reg, kept_reg[IDX_W-1:0]);
                        wr_data   = rd_data;
                        kept_fin  = kept_reg + 1'b1;
                        kept_next = kept_fin;
                    end
                    if (em_cnt_reg == occ_reg - 1'b1)
                    begin
                        removed           = occ_reg - kept_fin;
                        removed_ext       = {{COUNT_W{1'b0}}, removed};
                        occ_next          = kept_fin;
                        have_res          = 1'b1;
                        res.status        = (removed == '0) ? ST_NONE : ST_OK;
                        res.removed_count = removed_ext[COUNT_W-1:0];
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (have_res)
        begin
            if (out_free)
            begin
                rsp_next       = res;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = res;
                state_next = S_FIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            rd_cnt_reg    <= '0;
            em_cnt_reg    <= '0;
            kept_reg      <= '0;
            rv_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            rd_cnt_reg    <= rd_cnt_next;
            em_cnt_reg    <= em_cnt_next;
            kept_reg      <= kept_next;
            rv_reg        <= rv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    // occupancy and front index stay inside the store
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CAP_CNT)
        else $error("occupancy above capacity");

    a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, front_reg} < CAP_SUM)
        else $error("front index outside store");

    // at most one read in flight ahead of the emitted entries
    a_list_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (rd_cnt_reg - em_cnt_reg) == {{(CNT_W-1){1'b0}}, rv_reg})
        else $error("list read and emit counts out of step");

    // only a list leaves a non-final item waiting
    a_last_list: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.last) |-> (state_reg == S_LIST))
        else $error("non-final item outside a list");

endmodule
